// ===== design/egcd_pkg.sv =====
// Shared types for the gcd core: item structs and controller/datapath links.
// Depends on nothing; used by every module in the design folder.
package egcd_pkg;

   localparam int FIELD_WIDTH = 63;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] first_value;
      logic [FIELD_WIDTH-1:0] second_value;
   } req_item_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] divisor;
      logic                   both_zero;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic step;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic a_zero;
      logic b_zero;
   } status_type;

endpackage

// ===== design/egcd_datapath.sv =====
// Operand registers, binary gcd step unit and result register.
// Depends on egcd_pkg; driven by egcd_ctrl through cmd_type and status_type.
module egcd_datapath #(
   parameter int DATA_WIDTH = 63
) (
   input  logic                 clock,
   input  egcd_pkg::req_item_type req_item,
   input  egcd_pkg::cmd_type    cmd,
   output egcd_pkg::status_type status,
   output egcd_pkg::rsp_item_type rsp_item
);

   localparam int SHIFT_WIDTH = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0]  a_ff, a_in;
   logic [DATA_WIDTH-1:0]  b_ff, b_in;
   logic [SHIFT_WIDTH-1:0] k_ff, k_in;
   logic                   zero_pair_ff, zero_pair_in;
   egcd_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [DATA_WIDTH-1:0]  diff_ab;
   logic [DATA_WIDTH-1:0]  diff_ba;
   logic [DATA_WIDTH-1:0]  base;
   logic [DATA_WIDTH-1:0]  result;

   assign diff_ab = a_ff - b_ff;
   assign diff_ba = b_ff - a_ff;
   assign base    = (a_ff == '0) ? b_ff : a_ff;
   assign result  = base << k_ff;

   assign status.a_zero = (a_ff == '0);
   assign status.b_zero = (b_ff == '0);

   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      zero_pair_in = zero_pair_ff;
      rsp_in       = rsp_ff;
      if (cmd.load) begin
         a_in         = req_item.first_value[DATA_WIDTH-1:0];
         b_in         = req_item.second_value[DATA_WIDTH-1:0];
         k_in         = '0;
         zero_pair_in = (a_in == '0) && (b_in == '0);
      end else if (cmd.step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + SHIFT_WIDTH'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = diff_ab >> 1;
         end else begin
            b_in = diff_ba >> 1;
         end
      end
      if (cmd.capture) begin
         rsp_in.divisor                 = '0;
         rsp_in.divisor[DATA_WIDTH-1:0] = result;
         rsp_in.both_zero               = zero_pair_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      k_ff         <= k_in;
      zero_pair_ff <= zero_pair_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

// ===== design/egcd_ctrl.sv =====
// Controller for the gcd core: load, iterate, capture, output valid.
// Depends on egcd_pkg; commands egcd_datapath and reads its status.
module egcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  egcd_pkg::status_type status,
   output egcd_pkg::cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic done;
   logic out_free;

   assign done     = status.a_zero || status.b_zero;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.capture = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!done) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.capture || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_capture_done: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (state_ff == ST_RUN) && done)
      else $error("capture before iteration finished");
   a_capture_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> rsp_valid)
      else $error("captured item not presented");
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> out_free)
      else $error("capture overwrote a pending item");
   a_load_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall)
      else $error("input not stalled after load");
`endif

endmodule

// ===== design/euclid_gcd_core.sv =====
// Top level of the gcd core: wires controller and datapath to the ports.
// Depends on egcd_pkg, egcd_ctrl and egcd_datapath.
//
// Computes the greatest common divisor of two unsigned operands with the
// binary (shift and subtract) form of Euclid's rule, one step per cycle.
// One pair is in work at a time. The single subtract-and-shift unit removes
// at least one operand bit each step; a pair with a zero operand takes no
// step. gcd(a,0) and gcd(0,a) give a; gcd(0,0) gives 0 with both_zero set.
// Operand bits at and above DATA_WIDTH are ignored. A finished result waits
// in an output register, so the next pair is accepted while it is still
// stalled.
module euclid_gcd_core #(
   parameter int DATA_WIDTH = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  egcd_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output egcd_pkg::rsp_item_type rsp_item
);

   egcd_pkg::cmd_type    cmd;
   egcd_pkg::status_type status;

   egcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   egcd_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
